[hdl/fshc_pkg.sv]
// Package for the fan speed hysteresis controller.
// Holds the speed code type, register indexes, field widths and reset values.
// No dependencies.
package fshc_pkg;

  localparam int RAW_W  = 15;
  localparam int DEG_W  = 8;
  localparam int TH_W   = 8;
  localparam int HYS_W  = 4;
  localparam int CMP_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int FRAC_BITS  = 7;

  typedef enum logic [1:0] {
    SPEED_OFF  = 2'd0,
    SPEED_LOW  = 2'd1,
    SPEED_MED  = 2'd2,
    SPEED_HIGH = 2'd3
  } speed_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_TH   = 3'd0,
    REG_MED_TH   = 3'd1,
    REG_HIGH_TH  = 3'd2,
    REG_HYST     = 3'd3,
    REG_PLAUS_MIN = 3'd4,
    REG_PLAUS_MAX = 3'd5
  } cfg_reg_t;

  localparam logic signed [TH_W-1:0] LOW_TH_RST    = 8'sd21;
  localparam logic signed [TH_W-1:0] MED_TH_RST    = 8'sd24;
  localparam logic signed [TH_W-1:0] HIGH_TH_RST   = 8'sd27;
  localparam logic        [HYS_W-1:0] HYST_RST     = 4'd1;
  localparam logic signed [TH_W-1:0] PLAUS_MIN_RST = -8'sd20;
  localparam logic signed [TH_W-1:0] PLAUS_MAX_RST = 8'sd50;

endpackage

[hdl/fshc_in_if.sv]
// Input request channel of the fan speed controller: one raw reading.
// Depends on fshc_pkg for the field width.
interface fshc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fshc_pkg::RAW_W-1:0]   raw_reading;

  modport source (output valid, output raw_reading, input ready);
  modport sink   (input valid, input raw_reading, output ready);
endinterface

[hdl/fshc_out_if.sv]
// Result request channel of the fan speed controller.
// Depends on fshc_pkg for the field widths.
interface fshc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fshc_pkg::DEG_W-1:0]   degrees;
  logic [1:0]                          speed;
  logic                                relay_low;
  logic                                relay_med;
  logic                                relay_high;
  logic                                changed;
  logic                                rejected;

  modport source (output valid, output degrees, output speed, output relay_low,
                  output relay_med, output relay_high, output changed,
                  output rejected, input ready);
  modport sink   (input valid, input degrees, input speed, input relay_low,
                  input relay_med, input relay_high, input changed,
                  input rejected, output ready);
endinterface

[hdl/fshc_cfg_if.sv]
// Configuration write channel of the fan speed controller.
// Depends on fshc_pkg for index and data widths.
interface fshc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [fshc_pkg::CFG_IDX_W-1:0]       index;
  logic [fshc_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/fan_speed_hysteresis_control_top.sv]
// Top level of the fan speed hysteresis controller.
// Depends on fshc_pkg and the fshc_in_if, fshc_out_if and fshc_cfg_if channels.
//
// One raw reading in 1/128 degree units goes in, one result comes out per
// request, at a sustained rate of one request per clock while results are
// taken. A request is held in the input register and is evaluated on its way
// into the result register; the speed state register is updated in the same
// cycle the result register loads, which is what lets the following request
// see the new speed without a bubble. While the result is held off, at most
// two requests are in flight and the input stalls. The reading is floored to
// whole degrees, checked against the plausible window (outside it the speed
// is held and rejected is set), and otherwise drives a four-state
// off/low/med/high machine with a single shared hysteresis on some transitions.
// The configuration port is always ready; write it only while no request is
// in flight. Indexes above the register list are ignored.
module fan_speed_hysteresis_control_top (
  input  logic          clk,
  input  logic          rst_n,
  fshc_in_if.sink       in_chan,
  fshc_out_if.source    out_chan,
  fshc_cfg_if.sink      cfg_chan
);

  // Configuration registers
  logic signed [fshc_pkg::TH_W-1:0]  low_th_r, med_th_r, high_th_r;
  logic        [fshc_pkg::HYS_W-1:0] hyst_r;
  logic signed [fshc_pkg::TH_W-1:0]  plaus_min_r, plaus_max_r;

  // Input stage
  logic                                s1_valid_r;
  logic signed [fshc_pkg::RAW_W-1:0]   s1_raw_r;

  // Speed state and result stage
  fshc_pkg::speed_t                    fan_speed_r, fan_speed_nxt;
  logic                                out_valid_r;
  logic signed [fshc_pkg::DEG_W-1:0]   deg_r;
  fshc_pkg::speed_t                    speed_r;
  logic                                relay_low_r, relay_med_r, relay_high_r;
  logic                                changed_r, rejected_r;

  logic                                in_take, out_load;
  logic signed [fshc_pkg::DEG_W-1:0]   deg_w;
  logic signed [fshc_pkg::CMP_W-1:0]   t_w, lo_w, md_w, hi_w, h_w;
  logic                                rej_w;
  fshc_pkg::speed_t                    eval_speed;

  // Handshake: advance the input stage whenever the result register frees up
  assign out_load = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || out_load;
  assign in_take = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_th_r    <= fshc_pkg::LOW_TH_RST;
      med_th_r    <= fshc_pkg::MED_TH_RST;
      high_th_r   <= fshc_pkg::HIGH_TH_RST;
      hyst_r      <= fshc_pkg::HYST_RST;
      plaus_min_r <= fshc_pkg::PLAUS_MIN_RST;
      plaus_max_r <= fshc_pkg::PLAUS_MAX_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        fshc_pkg::REG_LOW_TH:    low_th_r    <= cfg_chan.data;
        fshc_pkg::REG_MED_TH:    med_th_r    <= cfg_chan.data;
        fshc_pkg::REG_HIGH_TH:   high_th_r   <= cfg_chan.data;
        fshc_pkg::REG_HYST:      hyst_r      <= cfg_chan.data[fshc_pkg::HYS_W-1:0];
        fshc_pkg::REG_PLAUS_MIN: plaus_min_r <= cfg_chan.data;
        fshc_pkg::REG_PLAUS_MAX: plaus_max_r <= cfg_chan.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= in_chan.raw_reading;
    end
  end

  // Floor to whole degrees: arithmetic shift drops the fraction bits
  assign deg_w = fshc_pkg::DEG_W'(s1_raw_r >>> fshc_pkg::FRAC_BITS);

  // Widen everything so threshold +/- hysteresis never wraps
  assign t_w  = fshc_pkg::CMP_W'(deg_w);
  assign lo_w = fshc_pkg::CMP_W'(low_th_r);
  assign md_w = fshc_pkg::CMP_W'(med_th_r);
  assign hi_w = fshc_pkg::CMP_W'(high_th_r);
  assign h_w  = signed'({{(fshc_pkg::CMP_W-fshc_pkg::HYS_W){1'b0}}, hyst_r});

  assign rej_w = (deg_w < plaus_min_r) || (deg_w > plaus_max_r);

  // Speed transitions, tested in fixed priority order per state
  always_comb begin
    eval_speed = fan_speed_r;
    unique case (fan_speed_r)
      fshc_pkg::SPEED_OFF: begin
        if (t_w >= hi_w)             eval_speed = fshc_pkg::SPEED_HIGH;
        else if (t_w >= md_w)        eval_speed = fshc_pkg::SPEED_MED;
        else if (t_w >= lo_w + h_w)  eval_speed = fshc_pkg::SPEED_LOW;
        else                         eval_speed = fshc_pkg::SPEED_OFF;
      end
      fshc_pkg::SPEED_LOW: begin
        if (t_w <= lo_w - h_w)       eval_speed = fshc_pkg::SPEED_OFF;
        else if (t_w >= hi_w)        eval_speed = fshc_pkg::SPEED_HIGH;
        else if (t_w >= md_w + h_w)  eval_speed = fshc_pkg::SPEED_MED;
        else                         eval_speed = fshc_pkg::SPEED_LOW;
      end
      fshc_pkg::SPEED_MED: begin
        if (t_w <= lo_w)             eval_speed = fshc_pkg::SPEED_OFF;
        else if (t_w <= md_w - h_w)  eval_speed = fshc_pkg::SPEED_LOW;
        else if (t_w >= hi_w + h_w)  eval_speed = fshc_pkg::SPEED_HIGH;
        else                         eval_speed = fshc_pkg::SPEED_MED;
      end
      fshc_pkg::SPEED_HIGH: begin
        if (t_w <= lo_w)             eval_speed = fshc_pkg::SPEED_OFF;
        else if (t_w <= md_w)        eval_speed = fshc_pkg::SPEED_LOW;
        else if (t_w <= hi_w - h_w)  eval_speed = fshc_pkg::SPEED_MED;
        else                         eval_speed = fshc_pkg::SPEED_HIGH;
      end
      default: eval_speed = fshc_pkg::SPEED_OFF;
    endcase
  end

  // Hold the speed on a rejected reading
  assign fan_speed_nxt = rej_w ? fan_speed_r : eval_speed;

  // Speed state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_speed_r <= fshc_pkg::SPEED_OFF;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        fan_speed_r <= fan_speed_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      deg_r        <= deg_w;
      speed_r      <= fan_speed_nxt;
      relay_low_r  <= (fan_speed_nxt == fshc_pkg::SPEED_LOW);
      relay_med_r  <= (fan_speed_nxt == fshc_pkg::SPEED_MED);
      relay_high_r <= (fan_speed_nxt == fshc_pkg::SPEED_HIGH);
      changed_r    <= (fan_speed_nxt != fan_speed_r);
      rejected_r   <= rej_w;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.degrees    = deg_r;
  assign out_chan.speed      = speed_r;
  assign out_chan.relay_low  = relay_low_r;
  assign out_chan.relay_med  = relay_med_r;
  assign out_chan.relay_high = relay_high_r;
  assign out_chan.changed    = changed_r;
  assign out_chan.rejected   = rejected_r;

  // A rejected reading never reports a speed change
  a_rej_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rejected_r && changed_r))
    else $error("rejected result flagged as changed");

  // A rejected reading leaves the speed state alone
  a_rej_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && rej_w) |=> (fan_speed_r == $past(fan_speed_r)))
    else $error("speed state moved on a rejected reading");

  // The offered speed is always the current state
  a_speed_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (speed_r == fan_speed_r))
    else $error("result speed differs from speed state");

endmodule
